/* rtl/iamn_pkg.sv */
// Shared types and constants for the image average and min-max stretch block.
package iamn_pkg;

	// Frame size and configuration register
	localparam int unsigned MAX_PIXELS_DEF = 65536;
	localparam int unsigned PIX_COUNT_W = 17;
	localparam logic [PIX_COUNT_W-1:0] PIX_COUNT_RST = 17'h10000;

	// Pixel range
	localparam int unsigned PIX_W = 8;
	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	// Command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PW = $clog2(QUEUE_DEPTH);

	// Input actions
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_EMIT = 1'b1;

	// Result status codes
	localparam logic STAT_OK = 1'b0;
	localparam logic STAT_NOT_READY = 1'b1;

	typedef struct packed {
		logic             action;
		logic [PIX_W-1:0] pixel_a;
		logic [PIX_W-1:0] pixel_b;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             last_pixel;
		logic             status;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_NOT_READY,
		CMD_READ
	} cmd_kind_t;

	// Work handed from the front to the back; the store address travels beside it
	typedef struct packed {
		cmd_kind_t        kind;
		logic             last;
		logic [PIX_W-1:0] pix;
		logic [PIX_W-1:0] fmin;
		logic [PIX_W-1:0] fmax;
	} cmd_t;

endpackage

/* rtl/iamn_front.sv */
// Front end: accepts items, tracks load and readout positions and the frame min/max.
module iamn_front #(
	parameter int unsigned MAX_PIXELS = iamn_pkg::MAX_PIXELS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	input  iamn_pkg::in_item_t                  item,
	input  logic [iamn_pkg::PIX_COUNT_W-1:0]    pixel_count,
	input  logic                                q_full,
	output logic                                push,
	output iamn_pkg::cmd_t                      push_cmd,
	output logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] push_addr
);

	localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
	localparam int unsigned XW = (CW > iamn_pkg::PIX_COUNT_W) ? CW : iamn_pkg::PIX_COUNT_W;

	logic [iamn_pkg::PIX_W-1:0] min_q;
	logic [iamn_pkg::PIX_W-1:0] max_q;
	logic [CW-1:0]              loaded_q;
	logic [AW-1:0]              rd_idx_q;

	logic                       accept;
	logic [XW-1:0]              pc_x;
	logic [XW-1:0]              ec_x;
	logic [CW-1:0]              ec;
	logic                       complete;
	logic [iamn_pkg::PIX_W:0]   sum;
	logic [iamn_pkg::PIX_W-1:0] fused;
	logic [CW:0]                rd_next;
	logic                       last;

	assign accept = item_valid && !q_full;

	// Clamp the configured count to 1..MAX_PIXELS
	always_comb begin
		pc_x = XW'(pixel_count);
		if (pc_x == '0) begin
			ec_x = XW'(1);
		end else if (pc_x > XW'(MAX_PIXELS)) begin
			ec_x = XW'(MAX_PIXELS);
		end else begin
			ec_x = pc_x;
		end
	end
	assign ec       = ec_x[CW-1:0];
	assign complete = (loaded_q >= ec);

	// Fuse the pair and decide whether this is the last readout pixel
	assign sum     = {1'b0, item.pixel_a} + {1'b0, item.pixel_b};
	assign fused   = sum[iamn_pkg::PIX_W:1];
	assign rd_next = (CW + 1)'(rd_idx_q) + (CW + 1)'(1);
	assign last    = (rd_next >= {1'b0, ec});

	// Classify the item into a command for the back end
	always_comb begin
		push          = 1'b0;
		push_cmd.kind = iamn_pkg::CMD_WRITE;
		push_cmd.last = last;
		push_cmd.pix  = fused;
		push_cmd.fmin = min_q;
		push_cmd.fmax = max_q;
		push_addr     = rd_idx_q;
		if (accept) begin
			if (item.action == iamn_pkg::ACT_LOAD) begin
				push      = !complete;
				push_addr = loaded_q[AW-1:0];
			end else if (!complete) begin
				push          = 1'b1;
				push_cmd.kind = iamn_pkg::CMD_NOT_READY;
			end else begin
				push          = 1'b1;
				push_cmd.kind = iamn_pkg::CMD_READ;
			end
		end
	end

	// Advance counters, track extremes, rearm after the last pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= iamn_pkg::PIX_MAX;
			max_q    <= '0;
			loaded_q <= '0;
			rd_idx_q <= '0;
		end else if (accept) begin
			if (item.action == iamn_pkg::ACT_LOAD) begin
				if (!complete) begin
					if (fused < min_q) min_q <= fused;
					if (fused > max_q) max_q <= fused;
					loaded_q <= loaded_q + CW'(1);
				end
			end else if (complete) begin
				if (last) begin
					min_q    <= iamn_pkg::PIX_MAX;
					max_q    <= '0;
					loaded_q <= '0;
					rd_idx_q <= '0;
				end else begin
					rd_idx_q <= rd_idx_q + AW'(1);
				end
			end
		end
	end

endmodule

/* rtl/iamn_queue.sv */
// Short command queue that decouples the front end from the back end.
module iamn_queue #(
	parameter int unsigned AW = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  iamn_pkg::cmd_t push_cmd,
	input  logic [AW-1:0]  push_addr,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output iamn_pkg::cmd_t pop_cmd,
	output logic [AW-1:0]  pop_addr
);

	localparam int unsigned PW = iamn_pkg::QUEUE_PW;
	localparam int unsigned DEPTH = iamn_pkg::QUEUE_DEPTH;

	iamn_pkg::cmd_t  cmd_q  [DEPTH];
	logic [AW-1:0]   addr_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == (PW + 1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_cmd   = cmd_q[rd_ptr_q];
	assign pop_addr  = addr_q[rd_ptr_q];

	// Hold entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			cmd_q[wr_ptr_q]  <= push_cmd;
			addr_q[wr_ptr_q] <= push_addr;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (do_pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			if (do_push && !do_pop) begin
				count_q <= count_q + (PW + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PW + 1)'(1);
			end
		end
	end

endmodule

/* rtl/iamn_back.sv */
// Back end: frame store, stretch divider and the result register.
module iamn_back #(
	parameter int unsigned MAX_PIXELS = iamn_pkg::MAX_PIXELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  iamn_pkg::cmd_t      q_cmd,
	input  logic [((MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1)-1:0] q_addr,
	output logic                q_pop,
	output logic                result_valid,
	input  logic                result_stall,
	output iamn_pkg::out_item_t result
);

	localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int unsigned PW = iamn_pkg::PIX_W;
	localparam int unsigned NW = 2 * PW;
	localparam int unsigned SW = $clog2(PW);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DIV,
		S_PUT
	} state_t;

	logic [PW-1:0]       mem [MAX_PIXELS];
	logic [PW-1:0]       rd_data_q;

	state_t              state_q;
	logic                res_valid_q;
	iamn_pkg::out_item_t res_q;
	logic [PW-1:0]       fmin_q;
	logic [PW-1:0]       fmax_q;
	logic                last_q;
	logic [PW-1:0]       rem_q;
	logic [PW-1:0]       quo_q;
	logic [PW-1:0]       range_q;
	logic [PW-1:0]       pix_q;
	logic [SW-1:0]       step_q;

	logic                out_free;
	logic                res_load;
	logic                do_write;
	logic                do_read;
	logic [PW-1:0]       diff;
	logic [NW-1:0]       num;
	logic [PW:0]         trial;
	logic                qbit;
	logic [PW:0]         trial_sub;

	assign out_free     = !res_valid_q || !result_stall;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Pop writes and reads at once; a not-ready reply waits for the output register
	always_comb begin
		q_pop = 1'b0;
		if (state_q == S_IDLE && q_not_empty) begin
			if (q_cmd.kind == iamn_pkg::CMD_NOT_READY) begin
				q_pop = out_free;
			end else begin
				q_pop = 1'b1;
			end
		end
	end
	assign do_write = q_pop && (q_cmd.kind == iamn_pkg::CMD_WRITE);
	assign do_read  = q_pop && (q_cmd.kind == iamn_pkg::CMD_READ);

	// Load the output register on a not-ready reply or a finished pixel
	assign res_load = (state_q == S_IDLE && q_pop && q_cmd.kind == iamn_pkg::CMD_NOT_READY) ||
		(state_q == S_PUT && out_free);

	// Frame store with registered read
	always_ff @(posedge clk) begin
		if (do_write) mem[q_addr] <= q_cmd.pix;
		if (do_read) rd_data_q <= mem[q_addr];
	end

	// Scale the offset by 255 and take one restoring step a cycle
	assign diff      = rd_data_q - fmin_q;
	assign num       = {diff, {PW{1'b0}}} - NW'(diff);
	assign trial     = {rem_q, pix_q[PW-1]};
	assign trial_sub = trial - {1'b0, range_q};
	assign qbit      = (trial >= {1'b0, range_q});

	// Sequence one command and hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			fmin_q      <= '0;
			fmax_q      <= '0;
			last_q      <= 1'b0;
			rem_q       <= '0;
			quo_q       <= '0;
			range_q     <= '0;
			pix_q       <= '0;
			step_q      <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						fmin_q <= q_cmd.fmin;
						fmax_q <= q_cmd.fmax;
						last_q <= q_cmd.last;
						if (q_cmd.kind == iamn_pkg::CMD_NOT_READY) begin
							res_q.pixel_out  <= '0;
							res_q.last_pixel <= 1'b0;
							res_q.status     <= iamn_pkg::STAT_NOT_READY;
						end else if (q_cmd.kind == iamn_pkg::CMD_READ) begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					if (fmax_q <= fmin_q || rd_data_q <= fmin_q) begin
						quo_q   <= '0;
						state_q <= S_PUT;
					end else if (rd_data_q >= fmax_q) begin
						quo_q   <= iamn_pkg::PIX_MAX;
						state_q <= S_PUT;
					end else begin
						rem_q   <= num[NW-1:PW];
						pix_q   <= num[PW-1:0];
						range_q <= fmax_q - fmin_q;
						step_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q  <= qbit ? trial_sub[PW-1:0] : trial[PW-1:0];
					pix_q  <= {pix_q[PW-2:0], qbit};
					step_q <= step_q + SW'(1);
					if (step_q == SW'(PW - 1)) begin
						quo_q   <= {pix_q[PW-2:0], qbit};
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						res_q.pixel_out  <= quo_q;
						res_q.last_pixel <= last_q;
						res_q.status     <= iamn_pkg::STAT_OK;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/image_average_minmax_normalize.sv */
// Top level: fuses two images, stores the frame and reads it out contrast-stretched.
//
// Input channel (item_valid / item_stall / item): action selects a load of one
// pixel pair or a request for the next stretched pixel. Loads beyond the frame
// size are taken and dropped. Loads give no result; each request gives one.
// Output channel (result_valid / result_stall / result): pixel_out, last_pixel
// and status. A request before the frame is full returns status not-ready.
// Configuration (cfg_valid / cfg_ready / cfg_data) writes pixel_count; write
// it only while the block is idle. 0 acts as 1, values above MAX_PIXELS clamp.
// Throughput: loads are taken one per cycle while the command queue has room;
// a load that fits the frame is written to the store when the back end pops
// it. A readout request runs through queue pop, registered store read, 8
// restoring divide steps (one quotient bit per cycle) and the result load;
// the divide steps are skipped when the pixel sits at the frame min or max or
// the frame is flat. A not-ready reply is one pop that loads the output register.
// A result also waits for any queued work ahead of it.
// Reset clears the counters, min/max and queue; the frame store is not cleared
// and is never read before it is written. When the receiver stalls, the result
// is held, the command queue (4 entries) fills, and then item_stall rises.
module image_average_minmax_normalize #(
	parameter int unsigned MAX_PIXELS = iamn_pkg::MAX_PIXELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  iamn_pkg::in_item_t               item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output iamn_pkg::out_item_t              result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [iamn_pkg::PIX_COUNT_W-1:0] cfg_data
);

	localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

	logic [iamn_pkg::PIX_COUNT_W-1:0] pixel_count_q;
	logic                             q_full;
	logic                             q_not_empty;
	logic                             push;
	logic                             pop;
	iamn_pkg::cmd_t                   push_cmd;
	iamn_pkg::cmd_t                   pop_cmd;
	logic [AW-1:0]                    push_addr;
	logic [AW-1:0]                    pop_addr;

	assign cfg_ready  = 1'b1;
	assign item_stall = q_full;

	// Hold the frame size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_count_q <= iamn_pkg::PIX_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			pixel_count_q <= cfg_data;
		end
	end

	iamn_front #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item        (item),
		.pixel_count (pixel_count_q),
		.q_full      (q_full),
		.push        (push),
		.push_cmd    (push_cmd),
		.push_addr   (push_addr)
	);

	iamn_queue #(
		.AW (AW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_addr (push_addr),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop_cmd   (pop_cmd),
		.pop_addr  (pop_addr)
	);

	iamn_back #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_cmd        (pop_cmd),
		.q_addr       (pop_addr),
		.q_pop        (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

/* sim/image_average_minmax_normalize_test.sv */
// Self-checking testbench for the image average and min-max stretch block.
`timescale 1ns / 1ps

module image_average_minmax_normalize_test;
	import iamn_pkg::*;

	localparam int unsigned CLK_HALF       = 4;
	localparam int unsigned RESET_CYCLES   = 4;
	localparam int unsigned QUIET_CYCLES   = 64;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS   = 600;
	localparam int unsigned ADDR_W         = $clog2(MAX_PIXELS_DEF);

	// Tracks the frame the block should hold and queues the pixels it owes
	class stretch_scoreboard;
		logic [PIX_W-1:0]       frame_px [MAX_PIXELS_DEF];
		logic [PIX_COUNT_W-1:0] count_reg;
		logic [PIX_W-1:0]       frame_min;
		logic [PIX_W-1:0]       frame_max;
		int unsigned            loaded;
		int unsigned            read_pos;
		out_item_t              owed_px[$];
		int unsigned            errors;
		int unsigned            work_items;
		int unsigned            n_stored, n_dropped, n_read, n_frames, n_early, n_flat;

		function new();
			count_reg = PIX_COUNT_RST;
			rearm();
			errors = 0;
			work_items = 0;
			n_stored = 0;
			n_dropped = 0;
			n_read = 0;
			n_frames = 0;
			n_early = 0;
			n_flat = 0;
		endfunction

		function void rearm();
			frame_min = PIX_MAX;
			frame_max = '0;
			loaded = 0;
			read_pos = 0;
		endfunction

		function void set_count(logic [PIX_COUNT_W-1:0] value);
			count_reg = value;
		endfunction

		// Clamp the register to 1..MAX_PIXELS
		function int unsigned frame_size();
			if (count_reg == 0) begin
				return 1;
			end
			if (count_reg > MAX_PIXELS_DEF) begin
				return MAX_PIXELS_DEF;
			end
			return 32'(count_reg);
		endfunction

		function int unsigned pending();
			return owed_px.size();
		endfunction

		function logic [PIX_W-1:0] stretch(logic [PIX_W-1:0] p);
			int unsigned span;
			if (frame_max <= frame_min || p <= frame_min) begin
				return '0;
			end
			if (p >= frame_max) begin
				return PIX_MAX;
			end
			span = 32'(frame_max) - 32'(frame_min);
			return PIX_W'((255 * (32'(p) - 32'(frame_min))) / span);
		endfunction

		// Predict the effect of one accepted transaction
		function void take_item(in_item_t it);
			logic [PIX_W:0]   sum;
			logic [PIX_W-1:0] p;
			out_item_t        r;
			int unsigned      size;
			size = frame_size();
			if (it.action == ACT_LOAD) begin
				if (loaded < size) begin
					sum = {1'b0, it.pixel_a} + {1'b0, it.pixel_b};
					p = sum[PIX_W:1];
					frame_px[ADDR_W'(loaded)] = p;
					if (p < frame_min) frame_min = p;
					if (p > frame_max) frame_max = p;
					loaded++;
					n_stored++;
					work_items++;
				end else begin
					n_dropped++;
				end
				return;
			end
			work_items++;
			if (loaded < size) begin
				r.pixel_out = '0;
				r.last_pixel = 1'b0;
				r.status = STAT_NOT_READY;
				owed_px.push_back(r);
				n_early++;
				return;
			end
			if (frame_max <= frame_min) n_flat++;
			r.pixel_out = stretch(frame_px[ADDR_W'(read_pos)]);
			r.last_pixel = (read_pos + 1 >= size);
			r.status = STAT_OK;
			owed_px.push_back(r);
			n_read++;
			if (r.last_pixel) begin
				n_frames++;
				rearm();
			end else begin
				read_pos++;
			end
		endfunction

		// Compare one accepted result with the oldest owed pixel
		function void check_result(out_item_t got);
			out_item_t want;
			if (owed_px.size() == 0) begin
				$error("unexpected result: pixel_out %0d, last_pixel %0b, status %0b",
					got.pixel_out, got.last_pixel, got.status);
				errors++;
				return;
			end
			want = owed_px.pop_front();
			if (got.pixel_out !== want.pixel_out) begin
				$error("pixel_out: expected %0d, got %0d", want.pixel_out, got.pixel_out);
				errors++;
			end
			if (got.last_pixel !== want.last_pixel) begin
				$error("last_pixel: expected %0b, got %0b", want.last_pixel, got.last_pixel);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0b, got %0b", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_stall;
	in_item_t               item = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	out_item_t              result;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [PIX_COUNT_W-1:0] cfg_data = '0;

	stretch_scoreboard board = new();
	int                send_burst = 0;
	int                recv_burst = 0;
	int unsigned       quiet_cycles = 0;

	image_average_minmax_normalize dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Draw a random wait length, with occasional runs of no waiting at all
	function automatic int draw_gap(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			burst = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	// Present one transaction and hold it until accepted
	task automatic send_item(input logic act, input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		int gap;
		gap = draw_gap(send_burst);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= '{action: act, pixel_a: a, pixel_b: b};
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		board.take_item(item);
	endtask

	task automatic send_load(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
		send_item(ACT_LOAD, a, b);
	endtask

	task automatic send_emit();
		send_item(ACT_EMIT, PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)));
	endtask

	// Hold off the sender until every owed result is back and the back end is quiet
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [PIX_COUNT_W-1:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_count(value);
	endtask

	function automatic logic [PIX_COUNT_W-1:0] pick_count();
		if ($urandom_range(0, 9) == 0) begin
			return '0;
		end
		if ($urandom_range(0, 4) == 0) begin
			return PIX_COUNT_W'($urandom_range(13, 48));
		end
		return PIX_COUNT_W'($urandom_range(1, 12));
	endfunction

	// Receiver: stall a random number of cycles before each result
	initial begin
		int wait_left;
		wait (arst_n);
		wait_left = draw_gap(recv_burst);
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				board.check_result(result);
				wait_left = draw_gap(recv_burst);
			end else if (wait_left > 0) begin
				wait_left--;
			end
			result_stall <= (wait_left > 0);
		end
	end

	// Watchdog: give up when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet_cycles++;
			end
		end
	end

	// Stimulus
	initial begin
		int unsigned      first_random;
		int unsigned      style;
		int unsigned      stop_at;
		int unsigned      n_emits;
		logic [PIX_W-1:0] flat_a, flat_b;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: request before any load, extremes, full-size frame left incomplete
		send_emit();
		send_load(8'd0, 8'd0);
		send_load(8'd255, 8'd255);
		send_load(8'd255, 8'd0);
		send_load(8'haa, 8'h55);
		send_load(8'd1, 8'd0);
		send_emit();

		// Oversized register clamps to the full frame, still not ready
		wait_drained();
		write_count('1);
		send_emit();

		// Shrink the frame below the loaded count: readout becomes possible
		wait_drained();
		write_count(17'd3);
		send_emit();
		send_emit();

		// Shrink below the read position: next pixel comes out as the last one
		wait_drained();
		write_count(17'd1);
		send_emit();

		// Zero acts as one: a flat single-pixel frame, extra load dropped
		wait_drained();
		write_count('0);
		send_load(8'd200, 8'd100);
		send_load(8'd10, 8'd10);
		send_emit();

		// Two-pixel frame: early request, then a load during readout is dropped
		wait_drained();
		write_count(17'd2);
		send_load(8'd30, 8'd31);
		send_emit();
		send_load(8'd0, 8'd255);
		send_emit();
		send_load(8'd99, 8'd99);
		send_emit();

		// Random frames, with register changes, early requests, dropped loads
		// and readouts cut short
		first_random = board.work_items;
		while (board.work_items - first_random < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				wait_drained();
				write_count(pick_count());
			end
			style = $urandom_range(0, 5);
			flat_a = PIX_W'($urandom_range(0, 255));
			flat_b = PIX_W'($urandom_range(0, 255));
			while (board.loaded < board.frame_size()) begin
				if ($urandom_range(0, 11) == 0) send_emit();
				case (style)
					0: begin
						send_load(flat_a, flat_b);
					end
					1: begin
						send_load($urandom_range(0, 1) ? PIX_MAX : 8'd0,
							$urandom_range(0, 1) ? PIX_MAX : 8'd0);
					end
					default: begin
						send_load(PIX_W'($urandom_range(0, 255)),
							PIX_W'($urandom_range(0, 255)));
					end
				endcase
			end
			if ($urandom_range(0, 4) == 0) begin
				send_load(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)));
			end
			stop_at = ($urandom_range(0, 7) == 0) ?
				$urandom_range(1, board.frame_size()) : board.frame_size();
			n_emits = 0;
			while (board.loaded != 0 && n_emits < stop_at) begin
				send_emit();
				n_emits++;
				if ($urandom_range(0, 11) == 0 && board.loaded != 0) begin
					send_load(PIX_W'($urandom_range(0, 255)),
						PIX_W'($urandom_range(0, 255)));
				end
			end
		end

		// Drain and report
		wait_drained();
		$display("%0d pixels stored, %0d loads dropped, %0d early requests answered",
			board.n_stored, board.n_dropped, board.n_early);
		$display("%0d stretched pixels read over %0d frame ends, %0d from flat frames",
			board.n_read, board.n_frames, board.n_flat);
		if (board.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/iamn_pkg.sv
rtl/iamn_front.sv
rtl/iamn_queue.sv
rtl/iamn_back.sv
rtl/image_average_minmax_normalize.sv
sim/image_average_minmax_normalize_test.sv
